// ===== src/thermal_zone_throttle_select_top_assert.svh =====
// Assertion macros shared by the checker of the throttle selector.
`ifndef THERMAL_ZONE_THROTTLE_SELECT_TOP_ASSERT_SVH
`define THERMAL_ZONE_THROTTLE_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TZTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TZTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tzts_pkg.sv =====
// Types and constants of the thermal zone throttle selector.
`default_nettype none
package tzts_pkg;
	localparam int DEF_MAX_ZONES = 16;
	localparam int DEF_CRIT_SAMPLES = 4;

	localparam int TEMP_W = 16;
	localparam int FREQ_W = 24;
	localparam int ZONE_W = 5;
	localparam int IDX_IN_W = 4;
	localparam int ZCNT_W = 5;
	localparam int CTEMP_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP = 2'd1;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// unthrottled zone code
	localparam logic signed [ZONE_W-1:0] ZONE_NONE = -5'sd1;

	typedef struct packed {
		logic operation;
		logic signed [TEMP_W-1:0] temperature;
		logic [IDX_IN_W-1:0] entry_index;
		logic [FREQ_W-1:0] entry_freq;
		logic signed [TEMP_W-1:0] entry_trip;
		logic signed [TEMP_W-1:0] entry_reset;
	} in_item_t;

	typedef struct packed {
		logic signed [ZONE_W-1:0] zone;
		logic [FREQ_W-1:0] freq_limit;
		logic zone_changed;
		logic shutdown_request;
	} out_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic signed [TEMP_W-1:0] trip;
		logic signed [TEMP_W-1:0] rst;
	} entry_t;
endpackage
`default_nettype wire

// ===== src/thermal_zone_throttle_select_top.sv =====
// Thermal zone throttle selector: zone table, hysteresis walk, shutdown voting.
//
// Usage: items enter on in_valid/in_ready. A write item (operation 1) loads
// one zone table entry in the cycle of its transfer and gives no result; the
// block stays ready. A sample item (operation 0) gives one result on
// out_valid/out_ready. Registers are written on cfg_valid/cfg_ready, which is
// always ready; write them only while the block is idle.
// A sample passes from its transfer through S_LOOK and S_DONE when zero
// zones are in use or the sample is critical, else through S_FETCH, S_FILL,
// S_WALK, which walks k zones (1 to the zones in use), one zone per cycle
// through the single table read port, S_LOOK, one read of the selected zone's
// cap, and S_DONE, which loads the result into the output register; in_ready
// stays low from the sample transfer until its result is loaded into the
// output register, so no new item is taken before then.
// A stalled receiver holds the result in the output register; the block
// takes new items meanwhile and only waits to load the next result.
// Reset clears the table (per-entry valid bits), both registers, the
// critical count and the output valid flag, and sets the zone to unthrottled.
`default_nettype none
module thermal_zone_throttle_select_top #(
	parameter int MAX_ZONES = tzts_pkg::DEF_MAX_ZONES,
	parameter int CRITICAL_SAMPLES = tzts_pkg::DEF_CRIT_SAMPLES
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tzts_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output tzts_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tzts_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tzts_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int IDX_W = $clog2(MAX_ZONES);
	localparam int NW = $clog2(MAX_ZONES + 1);
	localparam int CNT_W = $clog2(CRITICAL_SAMPLES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_FILL = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_LOOK = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;

	tzts_pkg::entry_t mem [MAX_ZONES];
	logic [MAX_ZONES-1:0] valid_q;
	tzts_pkg::entry_t rd_q;
	logic rd_hit_q;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	tzts_pkg::entry_t rd_entry;

	logic [tzts_pkg::ZCNT_W-1:0] zone_count_q;
	logic [tzts_pkg::CTEMP_W-1:0] crit_temp_q;
	logic [CNT_W-1:0] crit_cnt_q;
	logic signed [tzts_pkg::ZONE_W-1:0] zone_q;
	logic signed [tzts_pkg::ZONE_W-1:0] old_q;
	logic signed [tzts_pkg::TEMP_W-1:0] temp_q;
	logic [NW-1:0] n_q;
	logic [IDX_W-1:0] i_q;
	tzts_pkg::entry_t cur_q;
	logic shut_q;

	logic out_valid_q;
	tzts_pkg::out_item_t out_q;

	logic in_xfer;
	logic sample_xfer;
	logic [7:0] n_wide;
	logic [NW-1:0] n_next;
	logic is_crit;
	logic [CNT_W:0] cnt_inc;
	logic [7:0] addr_ahead;
	logic ahead_ok;
	logic [7:0] zone_ext;
	logic zone_in_range;
	logic [7:0] i_wide;
	logic signed [7:0] i_signed;

	logic step_done;
	logic step_set;
	logic signed [tzts_pkg::ZONE_W-1:0] step_zone;
	logic last_zone;
	logic first_zone;
	logic was_thr;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = !out_valid_q || out_ready;

	assign in_xfer = in_valid && in_ready;
	assign sample_xfer = in_xfer && (in_data.operation == tzts_pkg::OP_SAMPLE);

	// zones in use, clamped to the table depth
	assign n_wide = (8'(zone_count_q) > 8'(MAX_ZONES)) ? 8'(MAX_ZONES) : 8'(zone_count_q);
	assign n_next = NW'(n_wide);

	assign is_crit = (crit_temp_q != '0) &&
		($signed({in_data.temperature[tzts_pkg::TEMP_W-1], in_data.temperature}) >=
		$signed({2'b00, crit_temp_q}));
	assign cnt_inc = (CNT_W + 1)'(crit_cnt_q) + (CNT_W + 1)'(1);

	assign i_wide = 8'(i_q);
	assign i_signed = i_wide;
	assign addr_ahead = i_wide + 8'd2;
	assign ahead_ok = addr_ahead < 8'(MAX_ZONES);

	assign zone_ext = 8'(zone_q[tzts_pkg::ZONE_W-2:0]);
	assign zone_in_range = !zone_q[tzts_pkg::ZONE_W-1] && (zone_ext < 8'(MAX_ZONES));

	// entries never written read as zero
	assign rd_entry = rd_hit_q ? rd_q : '0;

	// table read port
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_FETCH: begin
				rd_en = 1'b1;
			end
			S_FILL: begin
				rd_en = 1'b1;
				rd_addr = IDX_W'(1);
			end
			S_WALK: begin
				rd_en = ahead_ok;
				rd_addr = addr_ahead[IDX_W-1:0];
			end
			S_LOOK: begin
				rd_en = zone_in_range;
				rd_addr = zone_ext[IDX_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// one zone of the walk: cur_q holds entry i, rd_entry holds entry i+1
	always_comb begin
		last_zone = (i_wide + 8'd1) == 8'(n_q);
		first_zone = (i_q == '0);
		was_thr = (old_q != tzts_pkg::ZONE_NONE);
		step_done = 1'b0;
		step_set = 1'b0;
		step_zone = zone_q;
		priority if (cur_q.freq == '0) begin
			step_done = 1'b1;
			step_set = 1'b1;
			step_zone = tzts_pkg::ZONE_W'(i_signed - 8'sd1);
		end else if (last_zone) begin
			step_done = 1'b1;
			step_set = 1'b1;
			step_zone = tzts_pkg::ZONE_W'(i_signed);
		end else if (temp_q > cur_q.rst) begin
			if ((temp_q < rd_entry.trip) && ((temp_q >= cur_q.trip) || was_thr)) begin
				step_done = 1'b1;
				step_set = 1'b1;
				step_zone = tzts_pkg::ZONE_W'(i_signed);
			end else if (first_zone && !was_thr) begin
				step_done = 1'b1;
			end
		end else if (first_zone) begin
			step_done = 1'b1;
			step_set = 1'b1;
			step_zone = tzts_pkg::ZONE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (in_data.operation == tzts_pkg::OP_WRITE) &&
			(32'(in_data.entry_index) < MAX_ZONES)) begin
			mem[IDX_W'(in_data.entry_index)] <= '{
				freq: in_data.entry_freq,
				trip: in_data.entry_trip,
				rst: in_data.entry_reset
			};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			rd_hit_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (in_xfer && (in_data.operation == tzts_pkg::OP_WRITE) &&
			(32'(in_data.entry_index) < MAX_ZONES)) begin
			valid_q[IDX_W'(in_data.entry_index)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_count_q <= '0;
			crit_temp_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tzts_pkg::CFG_ZONE_COUNT: zone_count_q <= cfg_data[tzts_pkg::ZCNT_W-1:0];
				tzts_pkg::CFG_CRIT_TEMP: crit_temp_q <= cfg_data[tzts_pkg::CTEMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sample payload captured at the transfer
	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			temp_q <= in_data.temperature;
			old_q <= zone_q;
			n_q <= n_next;
			i_q <= '0;
		end else if (state_q == S_WALK) begin
			i_q <= i_q + IDX_W'(1);
		end
		if ((state_q == S_FILL) || (state_q == S_WALK)) begin
			cur_q <= rd_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zone_q <= tzts_pkg::ZONE_NONE;
			crit_cnt_q <= '0;
			shut_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_xfer) begin
						shut_q <= 1'b0;
						priority if (n_next == '0) begin
							state_q <= S_LOOK;
						end else if (is_crit) begin
							// hold the zone and count the vote
							if (cnt_inc >= (CNT_W + 1)'(CRITICAL_SAMPLES)) begin
								shut_q <= 1'b1;
								crit_cnt_q <= '0;
							end else begin
								crit_cnt_q <= cnt_inc[CNT_W-1:0];
							end
							state_q <= S_LOOK;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: state_q <= S_FILL;
				S_FILL: state_q <= S_WALK;
				S_WALK: begin
					if (step_set) begin
						zone_q <= step_zone;
					end
					if (step_done) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_q.zone <= zone_q;
			out_q.freq_limit <= zone_in_range ? rd_entry.freq : '0;
			out_q.zone_changed <= (zone_q != old_q);
			out_q.shutdown_request <= shut_q;
		end
	end
endmodule
`default_nettype wire

// ===== src/tzts_check.sv =====
// Port-level checker for the throttle selector, bound to the top level.
`default_nettype none
`include "thermal_zone_throttle_select_top_assert.svh"
module tzts_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire tzts_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire tzts_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [tzts_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tzts_pkg::CFG_DATA_W-1:0] cfg_data
);
	logic sample_xfer;
	logic write_xfer;

	assign sample_xfer = in_valid && in_ready &&
		(in_data.operation == tzts_pkg::OP_SAMPLE);
	assign write_xfer = in_valid && in_ready &&
		(in_data.operation == tzts_pkg::OP_WRITE);

	// a stalled result holds
	`TZTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// a sample transfer makes the block busy
	`TZTS_ASSERT_NEXT(a_busy_after_sample, sample_xfer, !in_ready, "ready right after a sample transfer")

	// a table write never produces a result
	`TZTS_ASSERT_NEXT(a_write_silent, write_xfer && !out_valid, !out_valid, "result after a table write")

	// unthrottled means no cap
	`TZTS_ASSERT_NOW(a_unthrottled_free, out_valid && (out_data.zone == tzts_pkg::ZONE_NONE), out_data.freq_limit == '0, "cap reported while unthrottled")

	// a shutdown vote holds the zone
	`TZTS_ASSERT_NOW(a_shutdown_holds, out_valid && out_data.shutdown_request, !out_data.zone_changed, "zone changed on a shutdown vote")

	logic unused_cfg;
	assign unused_cfg = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);
endmodule

bind thermal_zone_throttle_select_top tzts_check u_tzts_check (.*);
`default_nettype wire

// ===== sim/throttle_select_checker.sv =====
// Checker of the throttle selector: predicts each sample's zone and compares results.
module throttle_select_checker #(
	parameter int MAX_ZONES = tzts_pkg::DEF_MAX_ZONES,
	parameter int CRITICAL_SAMPLES = tzts_pkg::DEF_CRIT_SAMPLES
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input tzts_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input tzts_pkg::out_item_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [tzts_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tzts_pkg::CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int open_results
);
	import tzts_pkg::*;

	logic [FREQ_W-1:0] cap_tab [MAX_ZONES];
	logic signed [TEMP_W-1:0] trip_tab [MAX_ZONES];
	logic signed [TEMP_W-1:0] rel_tab [MAX_ZONES];
	logic signed [ZONE_W-1:0] held_zone;
	int crit_votes;
	logic [ZCNT_W-1:0] zones_used;
	logic [CTEMP_W-1:0] crit_level;

	out_item_t zone_results_due [$];
	out_item_t due_item;

	task automatic flag(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Walk the zone table for one sample; update held zone and vote count.
	function automatic out_item_t select_zone(input logic signed [TEMP_W-1:0] sample_temp);
		out_item_t r;
		int t;
		int span;
		logic signed [ZONE_W-1:0] prior;
		bit vote;
		t = sample_temp;
		prior = held_zone;
		span = (zones_used > MAX_ZONES) ? MAX_ZONES : zones_used;
		vote = 0;
		for (int i = 0; i < span; i++) begin
			if (crit_level != 0 && t >= int'(crit_level)) begin
				if (crit_votes + 1 >= CRITICAL_SAMPLES) begin
					vote = 1;
					crit_votes = 0;
				end else begin
					crit_votes++;
				end
				break;
			end
			if (cap_tab[i] == 0) begin
				held_zone = ZONE_W'(i - 1);
				break;
			end
			if (i == span - 1) begin
				held_zone = ZONE_W'(i);
				break;
			end
			if (t > rel_tab[i]) begin
				if (t < trip_tab[i+1] && (t >= trip_tab[i] || prior != ZONE_NONE)) begin
					held_zone = ZONE_W'(i);
					break;
				end else if (i == 0 && prior == ZONE_NONE) begin
					break;
				end
			end else if (i == 0) begin
				held_zone = ZONE_NONE;
				break;
			end
		end
		r.zone = held_zone;
		// a stale zone reads whatever the table holds now
		r.freq_limit = (held_zone >= 0) ? cap_tab[int'(held_zone)] : '0;
		r.zone_changed = (held_zone != prior);
		r.shutdown_request = vote;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ZONES; i++) begin
				cap_tab[i] = '0;
				trip_tab[i] = '0;
				rel_tab[i] = '0;
			end
			held_zone = ZONE_NONE;
			crit_votes = 0;
			zones_used = '0;
			crit_level = '0;
			zone_results_due.delete();
			open_results = 0;
			fail_count = 0;
		end else begin
			// retire results before taking new transfers
			if (out_valid && out_ready) begin
				if (zone_results_due.size() == 0) begin
					flag($sformatf("result with none due: zone %0d freq %0d",
						out_data.zone, out_data.freq_limit));
				end else begin
					due_item = zone_results_due.pop_front();
					if (out_data.zone !== due_item.zone)
						flag($sformatf("zone %0d, want %0d", out_data.zone, due_item.zone));
					if (out_data.freq_limit !== due_item.freq_limit)
						flag($sformatf("freq_limit %0d, want %0d",
							out_data.freq_limit, due_item.freq_limit));
					if (out_data.zone_changed !== due_item.zone_changed)
						flag($sformatf("zone_changed %b, want %b",
							out_data.zone_changed, due_item.zone_changed));
					if (out_data.shutdown_request !== due_item.shutdown_request)
						flag($sformatf("shutdown_request %b, want %b",
							out_data.shutdown_request, due_item.shutdown_request));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ZONE_COUNT)
					zones_used = cfg_data[ZCNT_W-1:0];
				else if (cfg_index == CFG_CRIT_TEMP)
					crit_level = cfg_data[CTEMP_W-1:0];
			end
			if (in_valid && in_ready) begin
				if (in_data.operation == OP_WRITE) begin
					if (int'(in_data.entry_index) < MAX_ZONES) begin
						cap_tab[in_data.entry_index] = in_data.entry_freq;
						trip_tab[in_data.entry_index] = in_data.entry_trip;
						rel_tab[in_data.entry_index] = in_data.entry_reset;
					end
				end else begin
					zone_results_due.push_back(select_zone(in_data.temperature));
				end
			end
			open_results = zone_results_due.size();
		end
	end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top of the throttle selector: clock, reset, stimulus and verdict.
module tb_top;
	import tzts_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 165;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int open_results;

	bit quiet;
	bit hold_long;

	thermal_zone_throttle_select_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	throttle_select_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.open_results(open_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb_top NOT OK");
		$finish;
	end

	// Receiver: draw a stall per result; a requested long hold-off stalls for HOLD_CYCLES.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_long) begin
				stall = HOLD_CYCLES;
				hold_long = 0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Hold valid and payload until the transfer; valid stays high for a back-to-back item.
	task automatic offer(input in_item_t item);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_sample(input int temp);
		in_item_t item;
		item.operation = OP_SAMPLE;
		item.temperature = TEMP_W'(temp);
		item.entry_index = IDX_IN_W'($urandom);
		item.entry_freq = FREQ_W'($urandom);
		item.entry_trip = TEMP_W'($urandom);
		item.entry_reset = TEMP_W'($urandom);
		offer(item);
	endtask

	task automatic load_entry(input int idx, input int freq, input int trip, input int rel);
		in_item_t item;
		item.operation = OP_WRITE;
		item.temperature = TEMP_W'($urandom);
		item.entry_index = IDX_IN_W'(idx);
		item.entry_freq = FREQ_W'(freq);
		item.entry_trip = TEMP_W'(trip);
		item.entry_reset = TEMP_W'(rel);
		offer(item);
	endtask

	// Drain all results, then let the block go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input int zc, input int ct);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ZONE_COUNT;
		cfg_data <= CFG_DATA_W'(zc);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_CRIT_TEMP;
		cfg_data <= CFG_DATA_W'(ct);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One setting: ascending table, then mostly samples around the trip points.
	task automatic run_phase(input int items);
		int zc;
		int span;
		int lo;
		int hi;
		int ct;
		int pick;
		int trips [16];
		case ($urandom_range(0, 6))
			0: zc = 0;
			1: zc = 1;
			2: zc = 2;
			3: zc = 16;
			4: zc = 31;
			default: zc = $urandom_range(3, 15);
		endcase
		span = (zc > 16) ? 16 : zc;
		trips[0] = int'($urandom_range(0, 2000)) - 1000;
		for (int i = 1; i < 16; i++)
			trips[i] = trips[i-1] + int'($urandom_range(3, 200));
		lo = trips[0] - 40;
		hi = ((span > 0) ? trips[span-1] : trips[0]) + 40;
		case ($urandom_range(0, 4))
			0: ct = 0;
			1: ct = 32767;
			2: ct = 1;
			default: begin
				ct = hi - int'($urandom_range(0, 60));
				if (ct < 1)
					ct = 1;
			end
		endcase
		settle();
		set_regs(zc, ct);
		for (int i = 0; i < span; i++)
			load_entry(i, ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 24'hFFFFFF)),
				trips[i], trips[i] - int'($urandom_range(0, 25)));
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				load_entry($urandom_range(0, 15), $urandom, $urandom, $urandom);
			else if (pick == 1)
				send_sample($urandom);
			else
				send_sample(lo + int'($urandom_range(0, hi - lo)));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ZONE_COUNT;
		cfg_data <= '0;
		quiet = 0;
		hold_long = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no zones in use: zone held, no vote even above the critical level
		send_sample(-32768);
		send_sample(32767);
		settle();
		set_regs(0, 1);
		send_sample(32767);

		settle();
		set_regs(4, 0);
		load_entry(0, 1000, 10, 5);
		load_entry(1, 24'hFFFFFF, 20, 15);
		load_entry(2, 500, 30, 25);
		load_entry(3, 1, 40, 35);
		load_entry(15, 24'hFFFFFF, -32768, 32767);
		send_sample(0);
		send_sample(12);
		send_sample(7);
		send_sample(3);
		send_sample(22);
		send_sample(45);
		send_sample(32767);
		send_sample(-32768);
		// zones with a zero cap stop the walk one below
		load_entry(2, 0, 30, 25);
		send_sample(45);
		load_entry(0, 0, 10, 5);
		send_sample(12);
		load_entry(0, 1000, 10, 5);

		// zone count above the table size; four critical samples raise shutdown
		settle();
		set_regs(31, 32767);
		repeat (4) send_sample(32767);
		send_sample(32766);

		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph % 3 == 2);
			if (ph == 3)
				hold_long = 1;
			run_phase(PHASE_ITEMS);
		end

		settle();
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
